### rtl/alte_pkg.sv
package alte_pkg;

    localparam logic [2:0] MODE_APPEND  = 3'd0;
    localparam logic [2:0] MODE_COUNT   = 3'd1;
    localparam logic [2:0] MODE_RANGE   = 3'd2;
    localparam logic [2:0] MODE_FIND    = 3'd3;
    localparam logic [2:0] MODE_DELETE  = 3'd4;
    localparam logic [2:0] MODE_INSERT  = 3'd5;
    localparam logic [2:0] MODE_DEDUPE  = 3'd6;
    localparam logic [2:0] MODE_READ    = 3'd7;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_BAD_POS   = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [31:0] value;
        logic signed [31:0] upper_bound;
        logic [7:0]         position;
    } in_word_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [7:0]         count;
        logic [6:0]         found_index;
        logic signed [31:0] read_value;
        logic [7:0]         length;
    } out_word_t;

    typedef struct packed {
        logic eq;
        logic in_range;
    } cmp_res_t;

endpackage

### rtl/array_list_table_engine_core.sv
// Ordered list engine: holds up to DEPTH signed 32-bit entries and a length.
// Input channel s_valid/s_ready/s_data carries one command word (mode, value,
// upper_bound, position); the result channel m_valid/m_ready/m_data returns
// exactly one result word per command (status, count, found_index,
// read_value, length).
// One command is worked at a time: s_ready is high only while the sequencer
// is idle. Every entry access goes through a single memory read port with
// registered data, so each visited entry takes a read state and a check or
// write state. Dedupe compares each entry with every kept entry through the
// one shared comparator.
// A finished result waits in the output register; while the receiver stalls
// the sequencer holds in its final state and takes no new command.
// Reset (aresetn low, synchronous) empties the list and drops any pending
// result; entry contents are not cleared and need no clearing pass.
module array_list_table_engine_core #(
    parameter int DEPTH = 128
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  alte_pkg::in_word_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output alte_pkg::out_word_t  m_data
);
    import alte_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);
    localparam int CW = (LW > 8) ? LW : 8;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_SCAN_RD = 4'd1;
    localparam logic [3:0] S_SCAN_CK = 4'd2;
    localparam logic [3:0] S_SHL_RD  = 4'd3;
    localparam logic [3:0] S_SHL_WR  = 4'd4;
    localparam logic [3:0] S_SHR_RD  = 4'd5;
    localparam logic [3:0] S_SHR_WR  = 4'd6;
    localparam logic [3:0] S_INS_WR  = 4'd7;
    localparam logic [3:0] S_DD_RDI  = 4'd8;
    localparam logic [3:0] S_DD_LDI  = 4'd9;
    localparam logic [3:0] S_DD_RDJ  = 4'd10;
    localparam logic [3:0] S_DD_CKJ  = 4'd11;
    localparam logic [3:0] S_DD_KEEP = 4'd12;
    localparam logic [3:0] S_RD_RD   = 4'd13;
    localparam logic [3:0] S_RD_GET  = 4'd14;
    localparam logic [3:0] S_FIN     = 4'd15;

    logic [3:0]    state_reg, state_next;
    logic [LW-1:0] len_reg, len_next;
    logic [LW-1:0] i_reg, i_next;
    logic [LW-1:0] j_reg, j_next;
    logic [LW-1:0] k_reg, k_next;
    logic [LW-1:0] cnt_reg, cnt_next;
    logic [LW-1:0] fidx_reg, fidx_next;
    logic [1:0]    st_reg, st_next;
    logic [31:0]   rval_reg, rval_next;
    logic [31:0]   cur_reg, cur_next;
    in_word_t      cmd_reg, cmd_next;
    logic          m_valid_reg, m_valid_next;
    out_word_t     m_data_reg, m_data_next;

    logic          we;
    logic [AW-1:0] waddr;
    logic [31:0]   wdata;
    logic [AW-1:0] raddr;
    logic [31:0]   rdata;
    logic [31:0]   cmp_b;
    cmp_res_t      cmp;

    logic          accept;
    logic          full;
    logic [CW-1:0] pos_w;
    logic [CW-1:0] len_w;
    logic [LW-1:0] i_inc;

    alte_mem #(.DEPTH(DEPTH)) u_mem (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    alte_cmp u_cmp (
        .a   (rdata),
        .b   (cmp_b),
        .hi  (cmd_reg.upper_bound),
        .res (cmp)
    );

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign full    = (len_reg == LW'(DEPTH));
    assign pos_w   = CW'(s_data.position);
    assign len_w   = CW'(len_reg);
    assign i_inc   = i_reg + LW'(1);
    assign cmp_b   = (state_reg == S_DD_CKJ) ? cur_reg : cmd_reg.value;

    // sequence one command over the shared memory port and comparator
    always_comb begin
        state_next   = state_reg;
        len_next     = len_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        k_next       = k_reg;
        cnt_next     = cnt_reg;
        fidx_next    = fidx_reg;
        st_next      = st_reg;
        rval_next    = rval_reg;
        cur_next     = cur_reg;
        cmd_next     = cmd_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        we           = 1'b0;
        waddr        = i_reg[AW-1:0];
        wdata        = cmd_reg.value;
        raddr        = i_reg[AW-1:0];

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cmd_next  = s_data;
                    i_next    = '0;
                    k_next    = '0;
                    cnt_next  = '0;
                    fidx_next = '0;
                    st_next   = ST_OK;
                    rval_next = '0;
                    state_next = S_FIN;
                    unique case (s_data.mode)
                        MODE_APPEND: begin
                            if (full) begin
                                st_next = ST_FULL;
                            end else begin
                                we       = 1'b1;
                                waddr    = len_reg[AW-1:0];
                                wdata    = s_data.value;
                                len_next = len_reg + LW'(1);
                            end
                        end
                        MODE_COUNT, MODE_RANGE: begin
                            if (len_reg != '0) state_next = S_SCAN_RD;
                        end
                        MODE_FIND, MODE_DELETE: begin
                            if (len_reg != '0) state_next = S_SCAN_RD;
                            else               st_next    = ST_NOT_FOUND;
                        end
                        MODE_INSERT: begin
                            j_next = len_reg;
                            if (pos_w > len_w)       st_next    = ST_BAD_POS;
                            else if (full)           st_next    = ST_FULL;
                            else if (pos_w == len_w) state_next = S_INS_WR;
                            else                     state_next = S_SHR_RD;
                        end
                        MODE_DEDUPE: begin
                            if (len_reg != '0) state_next = S_DD_RDI;
                        end
                        default: begin
                            if (pos_w >= len_w) st_next    = ST_BAD_POS;
                            else                state_next = S_RD_RD;
                        end
                    endcase
                end
            end
            S_SCAN_RD: begin
                state_next = S_SCAN_CK;
            end
            S_SCAN_CK: begin
                if (cmd_reg.mode == MODE_COUNT || cmd_reg.mode == MODE_RANGE) begin
                    if ((cmd_reg.mode == MODE_COUNT) ? cmp.eq : cmp.in_range) begin
                        cnt_next = cnt_reg + LW'(1);
                    end
                    if (i_inc == len_reg) state_next = S_FIN;
                    else begin
                        i_next     = i_inc;
                        state_next = S_SCAN_RD;
                    end
                end else if (cmp.eq) begin
                    fidx_next = i_reg;
                    j_next    = i_reg;
                    if (cmd_reg.mode == MODE_FIND) state_next = S_FIN;
                    else if (i_inc < len_reg)      state_next = S_SHL_RD;
                    else begin
                        len_next   = len_reg - LW'(1);
                        state_next = S_FIN;
                    end
                end else if (i_inc == len_reg) begin
                    st_next    = ST_NOT_FOUND;
                    state_next = S_FIN;
                end else begin
                    i_next     = i_inc;
                    state_next = S_SCAN_RD;
                end
            end
            // close the gap: entry j takes entry j+1
            S_SHL_RD: begin
                raddr      = AW'(j_reg + LW'(1));
                state_next = S_SHL_WR;
            end
            S_SHL_WR: begin
                we     = 1'b1;
                waddr  = j_reg[AW-1:0];
                wdata  = rdata;
                j_next = j_reg + LW'(1);
                if ((j_reg + LW'(2)) < len_reg) state_next = S_SHL_RD;
                else begin
                    len_next   = len_reg - LW'(1);
                    state_next = S_FIN;
                end
            end
            // open a gap: entry j takes entry j-1
            S_SHR_RD: begin
                raddr      = AW'(j_reg - LW'(1));
                state_next = S_SHR_WR;
            end
            S_SHR_WR: begin
                we     = 1'b1;
                waddr  = j_reg[AW-1:0];
                wdata  = rdata;
                j_next = j_reg - LW'(1);
                if (CW'(j_reg - LW'(1)) == CW'(cmd_reg.position)) state_next = S_INS_WR;
                else                                              state_next = S_SHR_RD;
            end
            S_INS_WR: begin
                we         = 1'b1;
                waddr      = cmd_reg.position[AW-1:0];
                wdata      = cmd_reg.value;
                len_next   = len_reg + LW'(1);
                state_next = S_FIN;
            end
            S_DD_RDI: begin
                state_next = S_DD_LDI;
            end
            S_DD_LDI: begin
                cur_next = rdata;
                j_next   = '0;
                if (k_reg == '0) state_next = S_DD_KEEP;
                else             state_next = S_DD_RDJ;
            end
            S_DD_RDJ: begin
                raddr      = j_reg[AW-1:0];
                state_next = S_DD_CKJ;
            end
            // drop entry i on a match with a kept entry
            S_DD_CKJ: begin
                if (cmp.eq) begin
                    if (i_inc == len_reg) begin
                        len_next   = k_reg;
                        state_next = S_FIN;
                    end else begin
                        i_next     = i_inc;
                        state_next = S_DD_RDI;
                    end
                end else if ((j_reg + LW'(1)) == k_reg) begin
                    state_next = S_DD_KEEP;
                end else begin
                    j_next     = j_reg + LW'(1);
                    state_next = S_DD_RDJ;
                end
            end
            S_DD_KEEP: begin
                we     = 1'b1;
                waddr  = k_reg[AW-1:0];
                wdata  = cur_reg;
                k_next = k_reg + LW'(1);
                if (i_inc == len_reg) begin
                    len_next   = k_reg + LW'(1);
                    state_next = S_FIN;
                end else begin
                    i_next     = i_inc;
                    state_next = S_DD_RDI;
                end
            end
            S_RD_RD: begin
                raddr      = cmd_reg.position[AW-1:0];
                state_next = S_RD_GET;
            end
            S_RD_GET: begin
                rval_next  = rdata;
                state_next = S_FIN;
            end
            // hold until the output register is free
            default: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next            = 1'b1;
                    m_data_next.status      = st_reg;
                    m_data_next.count       = 8'(cnt_reg);
                    m_data_next.found_index = 7'(fidx_reg);
                    m_data_next.read_value  = rval_reg;
                    m_data_next.length      = 8'(len_reg);
                    state_next              = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            len_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            m_valid_reg <= m_valid_next;
        end
        i_reg      <= i_next;
        j_reg      <= j_next;
        k_reg      <= k_next;
        cnt_reg    <= cnt_next;
        fidx_reg   <= fidx_next;
        st_reg     <= st_next;
        rval_reg   <= rval_next;
        cur_reg    <= cur_next;
        cmd_reg    <= cmd_next;
        m_data_reg <= m_data_next;
    end

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LW'(DEPTH))
        else $error("list length beyond depth");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("command accepted while previous one still running");

    a_dd_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DD_CKJ || state_reg == S_DD_KEEP) |-> (k_reg <= i_reg))
        else $error("dedupe kept count ahead of scan index");

    a_shl_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SHL_WR) |-> ((j_reg + LW'(1)) < len_reg))
        else $error("left shift beyond list end");

    a_fin_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FIN && (!m_valid_reg || m_ready)) |=> (m_valid_reg && s_ready))
        else $error("result not issued on completion");
endmodule

### rtl/alte_mem.sv
module alte_mem #(
    parameter int DEPTH = 128
) (
    input  logic                      aclk,
    input  logic                      we,
    input  logic [$clog2(DEPTH)-1:0]  waddr,
    input  logic [31:0]               wdata,
    input  logic [$clog2(DEPTH)-1:0]  raddr,
    output logic [31:0]               rdata
);
    logic [31:0] mem [DEPTH];

    // write one entry, read one entry with registered data
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### rtl/alte_cmp.sv
module alte_cmp (
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    input  logic signed [31:0] hi,
    output alte_pkg::cmp_res_t res
);
    import alte_pkg::*;

    // equality against b, inclusive range b..hi
    always_comb begin
        res.eq       = (a == b);
        res.in_range = (b <= a) && (a <= hi);
    end
endmodule

### bench/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import alte_pkg::*;

    localparam int DEPTH = 128;
    localparam int STALL_LIMIT = 200000;
    localparam int RANDOM_WORDS = 65;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_word_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_word_t m_data;

    always #1 aclk = ~aclk;

    array_list_table_engine_core #(.DEPTH(DEPTH)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // list model used by the predictor
    logic signed [31:0] list_vals [DEPTH];
    int unsigned list_len;

    in_word_t pending_cmds[$];
    out_word_t expected_results[$];
    int mismatches = 0;
    int unexpected = 0;
    int results_seen = 0;
    int mode_hits[8];
    int status_hits[4];
    bit calm = 1'b0;
    int idle_cycles = 0;

    function automatic out_word_t apply_command(in_word_t c);
        out_word_t r;
        int unsigned kept;
        bit dup;
        bit hit;
        r = '0;
        case (c.mode)
            MODE_APPEND: begin
                if (list_len >= DEPTH) r.status = ST_FULL;
                else begin
                    list_vals[list_len] = c.value;
                    list_len++;
                end
            end
            MODE_COUNT: begin
                for (int i = 0; i < list_len; i++)
                    if (list_vals[i] == c.value) r.count++;
            end
            MODE_RANGE: begin
                for (int i = 0; i < list_len; i++)
                    if (c.value <= list_vals[i] && list_vals[i] <= c.upper_bound) r.count++;
            end
            MODE_FIND, MODE_DELETE: begin
                hit = 1'b0;
                for (int i = 0; i < list_len && !hit; i++)
                    if (list_vals[i] == c.value) begin
                        hit = 1'b1;
                        r.found_index = 7'(i);
                    end
                if (!hit) r.status = ST_NOT_FOUND;
                else if (c.mode == MODE_DELETE) begin
                    for (int i = r.found_index; i + 1 < list_len; i++)
                        list_vals[i] = list_vals[i + 1];
                    list_len--;
                end
            end
            MODE_INSERT: begin
                if (c.position > list_len) r.status = ST_BAD_POS;
                else if (list_len >= DEPTH) r.status = ST_FULL;
                else begin
                    for (int i = list_len; i > c.position; i--)
                        list_vals[i] = list_vals[i - 1];
                    list_vals[c.position] = c.value;
                    list_len++;
                end
            end
            MODE_DEDUPE: begin
                kept = 0;
                for (int i = 0; i < list_len; i++) begin
                    dup = 1'b0;
                    for (int j = 0; j < kept; j++)
                        if (list_vals[i] == list_vals[j]) dup = 1'b1;
                    if (!dup) begin
                        list_vals[kept] = list_vals[i];
                        kept++;
                    end
                end
                list_len = kept;
            end
            default: begin
                if (c.position >= list_len) r.status = ST_BAD_POS;
                else r.read_value = list_vals[c.position];
            end
        endcase
        r.length = 8'(list_len);
        return r;
    endfunction

    // values drawn from a small pool so matches and duplicates are common
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom();
            default: return $urandom_range(0, 7) - 3;
        endcase
    endfunction

    function automatic in_word_t make_cmd(logic [2:0] m, logic [31:0] v,
                                          logic [31:0] ub, logic [7:0] p);
        in_word_t c;
        c.mode = m;
        c.value = v;
        c.upper_bound = ub;
        c.position = p;
        return c;
    endfunction

    // driver: present the next word, hold it until accepted, idle in bursts
    int send_gap = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                if (!calm && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 14);
            end
            if (!(s_valid && !s_ready)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    s_data <= pending_cmds.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // predict on acceptance
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            expected_results.push_back(apply_command(s_data));
            mode_hits[s_data.mode]++;
        end
    end

    // monitor: stall in bursts, compare each accepted result word
    int recv_gap = 0;
    always @(posedge aclk) begin
        out_word_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                results_seen++;
                status_hits[m_data.status]++;
                if (expected_results.size() == 0) begin
                    unexpected++;
                    $display("unexpected result word %p", m_data);
                end else begin
                    want = expected_results.pop_front();
                    if (m_data !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p got %p", want, m_data);
                    end
                end
            end
            if (!calm && recv_gap == 0 && $urandom_range(0, 7) == 0)
                recv_gap = $urandom_range(1, 14);
            if (recv_gap > 0) begin
                recv_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog: count cycles with no word accepted on either side
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no progress, %0d results outstanding", expected_results.size());
            $display("array_list_table_engine_core regression: fail");
            $finish;
        end
    end

    initial begin
        logic [2:0] m;
        int fill;
        // directed part: edge values, every mode, each corner case
        pending_cmds.push_back(make_cmd(MODE_READ, 0, 0, 0));
        pending_cmds.push_back(make_cmd(MODE_FIND, 5, 0, 0));
        pending_cmds.push_back(make_cmd(MODE_DELETE, 5, 0, 0));
        pending_cmds.push_back(make_cmd(MODE_INSERT, 9, 0, 1));
        pending_cmds.push_back(make_cmd(MODE_INSERT, 32'h8000_0000, 0, 0));
        pending_cmds.push_back(make_cmd(MODE_APPEND, 32'h7fff_ffff, 0, 0));
        pending_cmds.push_back(make_cmd(MODE_APPEND, 32'hffff_ffff, 0, 0));
        pending_cmds.push_back(make_cmd(MODE_INSERT, 32'h7fff_ffff, 0, 1));
        pending_cmds.push_back(make_cmd(MODE_INSERT, 0, 0, 4));
        pending_cmds.push_back(make_cmd(MODE_INSERT, 3, 0, 8'hff));
        pending_cmds.push_back(make_cmd(MODE_COUNT, 32'h7fff_ffff, 0, 0));
        pending_cmds.push_back(make_cmd(MODE_RANGE, 32'h8000_0000, 32'h7fff_ffff, 0));
        pending_cmds.push_back(make_cmd(MODE_RANGE, 5, -5, 0));
        pending_cmds.push_back(make_cmd(MODE_RANGE, -1, 0, 0));
        pending_cmds.push_back(make_cmd(MODE_FIND, 0, 0, 0));
        pending_cmds.push_back(make_cmd(MODE_READ, 32'hffff_ffff, 32'hffff_ffff, 3));
        pending_cmds.push_back(make_cmd(MODE_READ, 0, 0, 5));
        pending_cmds.push_back(make_cmd(MODE_READ, 0, 0, 8'hff));
        pending_cmds.push_back(make_cmd(MODE_DEDUPE, 0, 0, 0));
        pending_cmds.push_back(make_cmd(MODE_DELETE, 32'h8000_0000, 0, 0));
        pending_cmds.push_back(make_cmd(MODE_DEDUPE, 0, 0, 0));
        // probe positions at and past the end of a short list
        pending_cmds.push_back(make_cmd(MODE_APPEND, 1, 0, 0));
        pending_cmds.push_back(make_cmd(MODE_INSERT, 1, 0, 8'd128));
        pending_cmds.push_back(make_cmd(MODE_INSERT, 1, 0, 8'd129));
        pending_cmds.push_back(make_cmd(MODE_COUNT, 2, 0, 0));
        pending_cmds.push_back(make_cmd(MODE_READ, 0, 0, 8'd127));
        pending_cmds.push_back(make_cmd(MODE_DEDUPE, 0, 0, 0));
        // random part: appends and inserts weighted up to keep the list populated
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            fill = $urandom_range(0, 15);
            if (fill < 4) m = MODE_APPEND;
            else if (fill < 6) m = MODE_INSERT;
            else if (fill == 6) m = MODE_DEDUPE;
            else m = 3'($urandom_range(1, 7));
            pending_cmds.push_back(make_cmd(m, pick_value(),
                $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 6) - 2,
                8'($urandom_range(0, 5) == 0 ? $urandom_range(0, 255)
                                             : $urandom_range(0, 12))));
        end
        // a few fully random words so every input bit toggles
        for (int n = 0; n < 8; n++)
            pending_cmds.push_back(make_cmd(3'($urandom_range(0, 7)), $urandom(), $urandom(),
                                            8'($urandom_range(0, 255))));
        list_len = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        // calm tail: no idling for the last stretch
        wait (pending_cmds.size() < 20);
        calm = 1'b1;
        wait (pending_cmds.size() == 0 && !s_valid);
        wait (expected_results.size() == 0);
        repeat (600) @(posedge aclk);
        $display("covered %0d result words; modes append..read hit %0d %0d %0d %0d %0d %0d %0d %0d",
                 results_seen, mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3],
                 mode_hits[4], mode_hits[5], mode_hits[6], mode_hits[7]);
        $display("status ok/not found/bad position/full seen %0d %0d %0d %0d",
                 status_hits[0], status_hits[1], status_hits[2], status_hits[3]);
        if (mismatches == 0 && unexpected == 0 && expected_results.size() == 0)
            $display("array_list_table_engine_core regression: pass");
        else
            $display("array_list_table_engine_core regression: fail");
        $finish;
    end
endmodule

### files.f
rtl/alte_pkg.sv
rtl/alte_mem.sv
rtl/alte_cmp.sv
rtl/array_list_table_engine_core.sv
bench/tb_top.sv
